@@ design/fqp_pkg.sv @@
// Package with the item types, codes and helper functions of the FASTQ record parser.
package fqp_pkg;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 13;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 3;

    localparam logic [DATA_W-1:0] BYTE_LF  = 8'd10;
    localparam logic [DATA_W-1:0] BYTE_CR  = 8'd13;
    localparam logic [DATA_W-1:0] BYTE_NUL = 8'd0;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

    localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SEQ     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_COMMENT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_QUAL    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STOP    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_SEQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUAL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLEAN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EARLY_END = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   item_kind;
        logic [DATA_W-1:0]   base_value;
        logic [STATUS_W-1:0] record_status;
        logic [LEN_W-1:0]    read_length;
        logic                last_of_run;
    } out_item_t;

    // Results caused by one input transfer: up to two items.
    typedef struct packed {
        logic [1:0] num;
        out_item_t  first;
        out_item_t  second;
    } step_result_t;

    function automatic out_item_t make_status(input logic [STATUS_W-1:0] status,
                                              input logic [LEN_W-1:0] len,
                                              input logic last);
        out_item_t item;
        item.item_kind     = KIND_STATUS;
        item.base_value    = '0;
        item.record_status = status;
        item.read_length   = (status == ST_DONE) ? len : '0;
        item.last_of_run   = last;
        return item;
    endfunction

    function automatic out_item_t make_base(input logic [KIND_W-1:0] kind,
                                            input logic [DATA_W-1:0] value);
        out_item_t item;
        item.item_kind     = kind;
        item.base_value    = value;
        item.record_status = ST_DONE;
        item.read_length   = '0;
        item.last_of_run   = 1'b1;
        return item;
    endfunction

endpackage

@@ design/fastq_record_parser.sv @@
// Top level of the streaming FASTQ record parser.
//
// Input channel (in_valid, in_stall, in_item): one file byte per transfer, or
// an end flag. Output channel (out_valid, out_stall, out_item): sequence bytes,
// quality bytes and record status items, in file order. Configuration channel
// (cfg_valid, cfg_ready, cfg_data): the maximum line length, always ready. The
// user must write it only while no transfer is in progress; nothing checks it.
//
// Each input transfer is parsed in the cycle it is taken and its results (none,
// one, or two at end of data) are written into a four-entry result queue,
// which offers them in order on the output. One byte per cycle is sustained;
// the input is held off only when the queue lacks room for two more items,
// which happens when the receiver stalls. A stalled output keeps its item
// until the transfer completes.
//
// Reset clears the parser to the start of a header line, empties the queue and
// sets the maximum line length to 4096. After any end or error status the block
// takes and discards all further bytes until reset.
module fastq_record_parser #(
    parameter int MAX_READ = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fqp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output fqp_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data
);
    import fqp_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             in_fire;
    logic             out_fire;
    logic             queue_almost_full;
    step_result_t     step_result;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_almost_full;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    fqp_parser #(
        .MAX_READ (MAX_READ)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_item (in_item),
        .max_len (max_len_reg),
        .result  (step_result)
    );

    fqp_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (step_result),
        .pop         (out_fire),
        .out_valid   (out_valid),
        .out_item    (out_item),
        .almost_full (queue_almost_full)
    );

endmodule

@@ design/fqp_parser.sv @@
// Line parser: per-byte state update and result generation for one input transfer.
module fqp_parser #(
    parameter int MAX_READ = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  fqp_pkg::in_item_t    in_item,
    input  logic [12:0]          max_len,
    output fqp_pkg::step_result_t result
);
    import fqp_pkg::*;

    localparam int CNT_W = $clog2(MAX_READ + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   seq_len_reg, seq_len_next;
    logic               after_cr_reg, after_cr_next;

    logic               at_end;
    logic               is_break;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   count_wide;
    logic [LEN_W-1:0]   seq_len_13;
    logic               count_zero;
    logic               len_match;

    assign at_end     = in_item.end_of_data || (in_item.data_byte == BYTE_NUL);
    assign is_break   = (in_item.data_byte == BYTE_LF) || (in_item.data_byte == BYTE_CR);
    assign limit      = (CMP_W'(max_len) > CMP_W'(MAX_READ)) ? CMP_W'(MAX_READ)
                                                             : CMP_W'(max_len);
    assign count_wide = CMP_W'(count_reg);
    assign seq_len_13 = LEN_W'(CMP_W'(seq_len_reg));
    assign count_zero = (count_reg == '0);
    assign len_match  = (count_reg == seq_len_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        seq_len_next  = seq_len_reg;
        after_cr_next = after_cr_reg;
        result        = '0;

        if (in_fire && (phase_reg != PH_STOP))
        begin
            after_cr_next = 1'b0;
            if (after_cr_reg && !at_end && (in_item.data_byte == BYTE_LF))
            begin
                // The LF of a CR LF pair is swallowed.
            end
            else if (at_end)
            begin
                phase_next = PH_STOP;
                result.num = 2'd1;
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        result.first = make_status(ST_CLEAN, seq_len_13, 1'b1);
                    end
                    PH_SEQ:
                    begin
                        result.first = make_status(count_zero ? ST_CLEAN : ST_EARLY_END,
                                                   seq_len_13, 1'b1);
                    end
                    PH_COMMENT:
                    begin
                        result.first = make_status(count_zero ? ST_EARLY_END : ST_CLEAN,
                                                   seq_len_13, 1'b1);
                    end
                    default:
                    begin
                        if (count_zero)
                        begin
                            result.first = make_status(ST_CLEAN, seq_len_13, 1'b1);
                        end
                        else if (len_match)
                        begin
                            result.num    = 2'd2;
                            result.first  = make_status(ST_DONE, seq_len_13, 1'b0);
                            result.second = make_status(ST_CLEAN, seq_len_13, 1'b1);
                        end
                        else
                        begin
                            result.first = make_status(ST_MISMATCH, seq_len_13, 1'b1);
                        end
                    end
                endcase
            end
            else if (is_break)
            begin
                after_cr_next = (in_item.data_byte == BYTE_CR);
                count_next    = '0;
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (count_zero)
                        begin
                            result.num   = 2'd1;
                            result.first = make_status(ST_CLEAN, seq_len_13, 1'b1);
                            phase_next   = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_SEQ;
                        end
                    end
                    PH_SEQ:
                    begin
                        if (count_zero)
                        begin
                            result.num   = 2'd1;
                            result.first = make_status(ST_CLEAN, seq_len_13, 1'b1);
                            phase_next   = PH_STOP;
                        end
                        else
                        begin
                            seq_len_next = count_reg;
                            phase_next   = PH_COMMENT;
                        end
                    end
                    PH_COMMENT:
                    begin
                        if (count_zero)
                        begin
                            result.num   = 2'd1;
                            result.first = make_status(ST_EARLY_END, seq_len_13, 1'b1);
                            phase_next   = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_QUAL;
                        end
                    end
                    default:
                    begin
                        result.num = 2'd1;
                        if (count_zero)
                        begin
                            result.first = make_status(ST_CLEAN, seq_len_13, 1'b1);
                            phase_next   = PH_STOP;
                        end
                        else if (len_match)
                        begin
                            result.first = make_status(ST_DONE, seq_len_13, 1'b1);
                            seq_len_next = '0;
                            phase_next   = PH_HEADER;
                        end
                        else
                        begin
                            result.first = make_status(ST_MISMATCH, seq_len_13, 1'b1);
                            phase_next   = PH_STOP;
                        end
                    end
                endcase
            end
            else if ((phase_reg == PH_SEQ) || (phase_reg == PH_QUAL))
            begin
                result.num = 2'd1;
                if (count_wide >= limit)
                begin
                    result.first = make_status(ST_OVERLONG, seq_len_13, 1'b1);
                    phase_next   = PH_STOP;
                end
                else
                begin
                    result.first = make_base((phase_reg == PH_SEQ) ? KIND_SEQ : KIND_QUAL,
                                             in_item.data_byte);
                    count_next   = count_reg + 1'b1;
                end
            end
            else
            begin
                // Header and comment text only needs to mark the line as non-empty.
                count_next = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            count_reg    <= '0;
            seq_len_reg  <= '0;
            after_cr_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            seq_len_reg  <= seq_len_next;
            after_cr_reg <= after_cr_next;
        end
    end

    // Once stopped, the parser stays stopped until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOP) |=> (phase_reg == PH_STOP))
        else $error("parser left the stopped phase");

    // A stopped parser produces no results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOP) |-> (result.num == 2'd0))
        else $error("result produced while stopped");

    // Two results only ever come as record done followed by clean end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.num == 2'd2) |-> ((result.first.record_status == ST_DONE) &&
                                  (result.second.record_status == ST_CLEAN) &&
                                  (phase_next == PH_STOP)))
        else $error("unexpected pair of results");

endmodule

@@ design/fqp_out_queue.sv @@
// Result queue: takes up to two items per cycle and delivers one per transfer.
module fqp_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fqp_pkg::step_result_t push,
    input  logic                  pop,
    output logic                  out_valid,
    output fqp_pkg::out_item_t    out_item,
    output logic                  almost_full
);
    import fqp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign out_valid    = (count_reg != '0);
    assign out_item     = mem[rd_ptr_reg];
    // Room for two more items is needed before the next input transfer.
    assign almost_full  = (count_reg > CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill level never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // Pointers and fill level stay consistent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(DEPTH)) |->
            (PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("result queue pointers disagree with fill level");

    // A pop with nothing pushed lowers the fill level by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.num == 2'd0)) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("result queue fill level wrong after a pop");

endmodule
